@@ rtl/foc_ftu_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// foc_ftu_pkg: shared types and constants of the frame transform unit
// Holds the transform codes, the stage payload types, the fixed-point
// constants and the function that builds the quarter-wave sine table.
// ----------------------------------------------------------------------------
package foc_ftu_pkg;

  localparam int unsigned SINE_TABLE_BITS_DEF = 10;

  // Fixed-point constants of the transforms.
  localparam logic [63:0] HALF_PI_Q30   = 64'd1686629713;
  localparam int          INV_SQRT3_Q16 = 37837;
  localparam int          SQRT3_Q15     = 56756;

  typedef enum logic [1:0] {
    KIND_CLARKE  = 2'd0,
    KIND_ICLARKE = 2'd1,
    KIND_PARK    = 2'd2,
    KIND_IPARK   = 2'd3
  } kind_e;

  // Payload after the sine lookup stage.
  typedef struct packed {
    kind_e       kind;
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] sin_v;
    logic [15:0] cos_v;
  } s1_t;

  // Payload after the multiplier stage.
  typedef struct packed {
    kind_e       kind;
    logic [15:0] x;
    logic [35:0] m0;
    logic [31:0] m1;
    logic [31:0] m2;
    logic [31:0] m3;
  } s2_t;

  // Quarter-wave sine entry idx, sin(pi/2 * idx / 2^(tbits-2)) in Q1.15, from a
  // Taylor series in Q30. Evaluated only at elaboration with constant arguments.
  function automatic logic [14:0] quarter_sine(input int unsigned idx,
                                               input int unsigned tbits);
    logic        [63:0] x;
    logic        [63:0] x2;
    logic        [63:0] term;
    logic signed [63:0] sum;
    logic        [63:0] rnd;
    x    = (64'(idx) * HALF_PI_Q30) >> (tbits - 2);
    x2   = (x * x) >> 30;
    sum  = $signed(x);
    term = ((x * x2) >> 30) / 6;
    sum  = sum - $signed(term);
    term = ((term * x2) >> 30) / 20;
    sum  = sum + $signed(term);
    term = ((term * x2) >> 30) / 42;
    sum  = sum - $signed(term);
    term = ((term * x2) >> 30) / 72;
    sum  = sum + $signed(term);
    term = ((term * x2) >> 30) / 110;
    sum  = sum - $signed(term);
    term = ((term * x2) >> 30) / 156;
    sum  = sum + $signed(term);
    term = ((term * x2) >> 30) / 210;
    sum  = sum - $signed(term);
    term = ((term * x2) >> 30) / 272;
    sum  = sum + $signed(term);
    if (sum < 0) begin
      sum = '0;
    end
    rnd = (64'(sum) + 64'd16384) >> 15;
    if (rnd > 64'd32767) begin
      rnd = 64'd32767;
    end
    return rnd[14:0];
  endfunction

endpackage
`default_nettype wire

@@ rtl/foc_ftu_sine.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// foc_ftu_sine: angle to sine and cosine lookup stage
// Folds the angle onto a quarter-wave table and registers sine, cosine and
// the operands of the item.
// ----------------------------------------------------------------------------
module foc_ftu_sine
  import foc_ftu_pkg::*;
#(
  parameter int unsigned SINE_TABLE_BITS = SINE_TABLE_BITS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        en_i,
  input  wire logic [1:0]  kind_i,
  input  wire logic [15:0] in_x_i,
  input  wire logic [15:0] in_y_i,
  input  wire logic [15:0] angle_i,
  output      s1_t         s1_o
);

  localparam int unsigned QB    = SINE_TABLE_BITS - 2;
  localparam int unsigned QSIZE = 1 << QB;
  localparam logic [14:0] PEAK  = quarter_sine(QSIZE, SINE_TABLE_BITS);

  logic [14:0] qtab [QSIZE];

  for (genvar gi = 0; gi < QSIZE; gi++) begin : g_tab
    assign qtab[gi] = quarter_sine(gi, SINE_TABLE_BITS);
  end

  logic [SINE_TABLE_BITS-1:0] n_sin;
  logic [SINE_TABLE_BITS-1:0] n_cos;
  logic [15:0]                sin_d;
  logic [15:0]                cos_d;
  s1_t                        s1_q;

  // Sine of table index n over the full turn.
  function automatic logic [15:0] fold(input logic [SINE_TABLE_BITS-1:0] n,
                                       input logic [14:0] tab [QSIZE]);
    logic [QB-1:0] r;
    logic          odd;
    logic [14:0]   mag;
    r   = n[QB-1:0];
    odd = n[QB];
    if (odd && (r == '0)) begin
      mag = PEAK;
    end else if (odd) begin
      mag = tab[QB'(-r)];
    end else begin
      mag = tab[r];
    end
    return n[QB+1] ? -{1'b0, mag} : {1'b0, mag};
  endfunction

  assign n_sin = angle_i[15 -: SINE_TABLE_BITS];
  assign n_cos = n_sin + SINE_TABLE_BITS'(QSIZE);
  assign sin_d = fold(n_sin, qtab);
  assign cos_d = fold(n_cos, qtab);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_q.kind  <= kind_e'(kind_i);
      s1_q.x     <= in_x_i;
      s1_q.y     <= in_y_i;
      s1_q.sin_v <= sin_d;
      s1_q.cos_v <= cos_d;
    end
  end

  assign s1_o = s1_q;

endmodule
`default_nettype wire

@@ rtl/foc_ftu_mult.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// foc_ftu_mult: product stage
// Forms four registered products; the rotation uses all four and the Clarke
// kinds only the first, whose multiplier they share with the rotation.
// ----------------------------------------------------------------------------
module foc_ftu_mult
  import foc_ftu_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic en_i,
  input  wire s1_t  s1_i,
  output      s2_t  s2_o
);

  logic signed [17:0] a0;
  logic signed [17:0] b0;
  logic signed [17:0] neg_sum;
  logic signed [15:0] xs;
  logic signed [15:0] ys;
  logic signed [15:0] ss;
  logic signed [15:0] cs;
  s2_t                s2_q;

  assign xs = $signed(s1_i.x);
  assign ys = $signed(s1_i.y);
  assign ss = $signed(s1_i.sin_v);
  assign cs = $signed(s1_i.cos_v);

  // -(a + 2b) needs 18 bits.
  assign neg_sum = -(18'(xs) + (18'(ys) <<< 1));

  always_comb begin
    case (s1_i.kind)
      KIND_CLARKE: begin
        a0 = neg_sum;
        b0 = 18'sd37837;
      end
      KIND_ICLARKE: begin
        a0 = 18'(ys);
        b0 = 18'sd56756;
      end
      default: begin
        a0 = 18'(ss);
        b0 = 18'(xs);
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s2_q.kind <= s1_i.kind;
      s2_q.x    <= s1_i.x;
      s2_q.m0   <= a0 * b0;
      s2_q.m1   <= cs * ys;
      s2_q.m2   <= cs * xs;
      s2_q.m3   <= ss * ys;
    end
  end

  assign s2_o = s2_q;

endmodule
`default_nettype wire

@@ rtl/foc_ftu_round.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// foc_ftu_round: sum, round and output register stage
// Adds the products of each result, rounds half up to Q2.15 and holds the
// three outputs.
// ----------------------------------------------------------------------------
module foc_ftu_round
  import foc_ftu_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        en_i,
  input  wire s2_t         s2_i,
  output      logic [16:0] out_x_o,
  output      logic [16:0] out_y_o,
  output      logic [16:0] out_z_o
);

  logic signed [35:0] m0;
  logic signed [35:0] m1;
  logic signed [35:0] m2;
  logic signed [35:0] m3;
  logic signed [35:0] px;
  logic signed [35:0] sum_x;
  logic signed [35:0] sum_y;
  logic signed [35:0] sum_z;
  logic        [16:0] ox_d;
  logic        [16:0] oy_d;
  logic        [16:0] oz_d;
  logic        [16:0] ox_q;
  logic        [16:0] oy_q;
  logic        [16:0] oz_q;

  assign m0 = $signed(s2_i.m0);
  assign m1 = $signed({{4{s2_i.m1[31]}}, s2_i.m1});
  assign m2 = $signed({{4{s2_i.m2[31]}}, s2_i.m2});
  assign m3 = $signed({{4{s2_i.m3[31]}}, s2_i.m3});
  assign px = $signed({{5{s2_i.x[15]}}, s2_i.x, 15'b0});

  always_comb begin
    sum_x = '0;
    sum_y = '0;
    sum_z = '0;
    ox_d  = {s2_i.x[15], s2_i.x};
    oy_d  = '0;
    oz_d  = '0;
    case (s2_i.kind)
      KIND_CLARKE: begin
        sum_y = m0 + 36'sd32768;
        oy_d  = 17'(sum_y >>> 16);
      end
      KIND_ICLARKE: begin
        sum_y = -px - m0 + 36'sd32768;
        sum_z = -px + m0 + 36'sd32768;
        oy_d  = 17'(sum_y >>> 16);
        oz_d  = 17'(sum_z >>> 16);
      end
      default: begin
        // Park and inverse Park share one rotation under this sign convention.
        sum_x = m0 + m1 + 36'sd16384;
        sum_y = m2 - m3 + 36'sd16384;
        ox_d  = 17'(sum_x >>> 15);
        oy_d  = 17'(sum_y >>> 15);
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ox_q <= ox_d;
      oy_q <= oy_d;
      oz_q <= oz_d;
    end
  end

  assign out_x_o = ox_q;
  assign out_y_o = oy_q;
  assign out_z_o = oz_q;

endmodule
`default_nettype wire

@@ rtl/foc_frame_transform_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// foc_frame_transform_unit: Clarke, inverse Clarke, Park and inverse Park
// Three-stage pipeline of frame transforms for field-oriented control.
// ----------------------------------------------------------------------------
// Usage:
// An item enters on the input channel (in_valid_i / in_ready_o) with a
// transform kind, two Q1.15 operands and a 16-bit electrical angle. One
// result item leaves on the output channel (out_valid_o / out_ready_i) with
// three Q2.15 values; out_z_o is phase c for inverse Clarke and zero else.
// An accepted item passes three register stages: a sine and cosine lookup
// stage, a multiplier stage and a sum-and-round stage, whose register is the
// output register. out_valid_o is the valid bit of that register.
// Throughput is one item per cycle while the receiver takes results, set by
// the four multipliers in the middle stage, each used once per item.
// Each stage has its own valid bit. When the receiver stalls, the output
// register holds its item, and the stages behind it keep filling until all
// three hold an item; only then does in_ready_o fall. Nothing is dropped or
// repeated. Reset clears the valid bits, so the pipeline comes up empty; the
// data registers are not reset. The block holds no state across items.
// ----------------------------------------------------------------------------
module foc_frame_transform_unit
  import foc_ftu_pkg::*;
#(
  parameter int unsigned SINE_TABLE_BITS = SINE_TABLE_BITS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output      logic        in_ready_o,
  input  wire logic [1:0]  kind_i,
  input  wire logic [15:0] in_x_i,
  input  wire logic [15:0] in_y_i,
  input  wire logic [15:0] angle_i,
  output      logic        out_valid_o,
  input  wire logic        out_ready_i,
  output      logic [16:0] out_x_o,
  output      logic [16:0] out_y_o,
  output      logic [16:0] out_z_o
);

  logic v1_q, v1_d;
  logic v2_q, v2_d;
  logic v3_q, v3_d;
  logic rdy1, rdy2, rdy3;
  s1_t  s1;
  s2_t  s2;

  // A stage may load when it is empty or when the stage after it moves on.
  assign rdy3 = !v3_q || out_ready_i;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;

  assign v1_d = rdy1 ? in_valid_i : v1_q;
  assign v2_d = rdy2 ? v1_q : v2_q;
  assign v3_d = rdy3 ? v2_q : v3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= v1_d;
      v2_q <= v2_d;
      v3_q <= v3_d;
    end
  end

  assign in_ready_o  = rdy1;
  assign out_valid_o = v3_q;

  foc_ftu_sine #(
    .SINE_TABLE_BITS(SINE_TABLE_BITS)
  ) u_sine (
    .clk_i  (clk_i),
    .en_i   (rdy1 && in_valid_i),
    .kind_i (kind_i),
    .in_x_i (in_x_i),
    .in_y_i (in_y_i),
    .angle_i(angle_i),
    .s1_o   (s1)
  );

  foc_ftu_mult u_mult (
    .clk_i(clk_i),
    .en_i (rdy2 && v1_q),
    .s1_i (s1),
    .s2_o (s2)
  );

  foc_ftu_round u_round (
    .clk_i  (clk_i),
    .en_i   (rdy3 && v2_q),
    .s2_i   (s2),
    .out_x_o(out_x_o),
    .out_y_o(out_y_o),
    .out_z_o(out_z_o)
  );

  // An accepted item always lands in the first stage.
  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> v1_q)
    else $error("accepted item did not reach the lookup stage");

  // The input side only blocks when every stage is full and the output stalls.
  a_block_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> v1_q && v2_q && v3_q && !out_ready_i)
    else $error("input blocked while the pipeline had room");

  // A stalled middle stage keeps its item untouched.
  a_mid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q && !rdy3 |=> v2_q && $stable(s2))
    else $error("middle stage item changed during a stall");

endmodule
`default_nettype wire
